// ===== rtl/cfsl_pkg.sv =====
package cfsl_pkg;

    // channel geometry
    localparam int CH_W      = 8;
    localparam int NUM_LANES = 4;
    localparam int IN_W      = 48;
    localparam int OUT_W     = 40;
    localparam int CFG_IDX_W = $clog2(NUM_LANES);

    // frame completion marker
    localparam logic [CH_W-1:0] FRAME_MARK = 8'h59;

    // command codes
    localparam logic [CH_W-1:0] CMD_LIGHT_ON  = 8'h10;
    localparam logic [CH_W-1:0] CMD_LIGHT_OFF = 8'h0E;
    localparam logic [CH_W-1:0] CMD_RUN_ON    = 8'h0D;
    localparam logic [CH_W-1:0] CMD_RUN_OFF   = 8'h0F;
    localparam logic [CH_W-1:0] CMD_HOLD_ON   = 8'h08;
    localparam logic [CH_W-1:0] CMD_HOLD_OFF  = 8'h06;
    localparam logic [CH_W-1:0] CMD_FULL_L    = 8'h09;
    localparam logic [CH_W-1:0] CMD_FULL_R    = 8'h0A;
    localparam logic [CH_W-1:0] CMD_HALF_L    = 8'h0B;
    localparam logic [CH_W-1:0] CMD_HALF_R    = 8'h0C;
    localparam logic [CH_W-1:0] CMD_SERVO_UP  = 8'h05;
    localparam logic [CH_W-1:0] CMD_SERVO_DN  = 8'h07;

    // thrust-turn and servo codes reported on the result
    typedef enum logic [2:0] {
        TURN_NONE   = 3'd0,
        TURN_HALF_R = 3'd1,
        TURN_HALF_L = 3'd2,
        TURN_FULL_R = 3'd3,
        TURN_FULL_L = 3'd4
    } t_turn;

    typedef enum logic [1:0] {
        SERVO_HOLD = 2'd0,
        SERVO_DOWN = 2'd1,
        SERVO_UP   = 2'd2
    } t_servo;

    // step limit reset values, lane order: angle, depth, side, forward
    typedef logic [NUM_LANES-1:0][CH_W-1:0] t_lane_bytes;
    localparam t_lane_bytes LIMIT_RESET = {8'd2, 8'd2, 8'd4, 8'd12};

    // sticky flags and codes held by the command decoder, light in the lowest bit
    typedef struct packed {
        logic   hold;
        t_servo servo;
        t_turn  turn;
        logic   run;
        logic   light;
    } t_cmd_state;

    // one result word before packing
    typedef struct packed {
        logic        frame_ok;
        t_cmd_state  cmd;
        t_lane_bytes chan;
    } t_result;

endpackage

// ===== rtl/cfsl_slew_lane.sv =====
module cfsl_slew_lane
    import cfsl_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_apply,
    input  logic [CH_W-1:0] i_want,
    input  logic [CH_W-1:0] i_limit,
    output logic [CH_W-1:0] o_next
);

    logic [CH_W-1:0]        r_last;
    logic signed [CH_W+1:0] diff;
    logic signed [CH_W+1:0] lim_s;
    logic [CH_W-1:0]        slewed;

    // signed clamp of the move toward the requested value
    always_comb begin
        diff  = $signed({2'b00, i_want}) - $signed({2'b00, r_last});
        lim_s = $signed({2'b00, i_limit});
        if (diff > lim_s) begin
            slewed = r_last + i_limit;
        end else if (diff < -lim_s) begin
            slewed = r_last - i_limit;
        end else begin
            slewed = i_want;
        end
        o_next = i_apply ? slewed : r_last;
    end

    // held channel value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else begin
            r_last <= o_next;
        end
    end

endmodule

// ===== rtl/cfsl_cmd_decode.sv =====
module cfsl_cmd_decode
    import cfsl_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_apply,
    input  logic [CH_W-1:0] i_cmd,
    output t_cmd_state      o_next
);

    t_cmd_state r_state;
    t_cmd_state decoded;

    // sticky flags keep their value, turn and servo fall back to zero
    always_comb begin
        decoded       = r_state;
        decoded.turn  = TURN_NONE;
        decoded.servo = SERVO_HOLD;
        unique case (i_cmd)
            CMD_LIGHT_ON:  decoded.light = 1'b1;
            CMD_LIGHT_OFF: decoded.light = 1'b0;
            CMD_RUN_ON:    decoded.run   = 1'b1;
            CMD_RUN_OFF:   decoded.run   = 1'b0;
            CMD_HOLD_ON:   decoded.hold  = 1'b1;
            CMD_HOLD_OFF:  decoded.hold  = 1'b0;
            CMD_FULL_L:    decoded.turn  = TURN_FULL_L;
            CMD_FULL_R:    decoded.turn  = TURN_FULL_R;
            CMD_HALF_L:    decoded.turn  = TURN_HALF_L;
            CMD_HALF_R:    decoded.turn  = TURN_HALF_R;
            CMD_SERVO_UP:  decoded.servo = SERVO_UP;
            CMD_SERVO_DN:  decoded.servo = SERVO_DOWN;
            default:       decoded       = decoded;
        endcase
        o_next = i_apply ? decoded : r_state;
    end

    // held flags and codes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= o_next;
        end
    end

endmodule

// ===== rtl/cfsl_out_stage.sv =====
module cfsl_out_stage
    import cfsl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  t_result          i_result,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_data,
    output logic             o_user
);

    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    pop;

    assign pop     = r_out_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;

    // merge lanes and decoder into one word
    assign o_data = {r_out.cmd, r_out.chan};
    assign o_user = r_out.frame_ok;

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= i_take;
                end
            end else if (i_take) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (pop || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_take) begin
                r_out <= i_result;
            end
        end else if (i_take) begin
            r_skid <= i_result;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a word while output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid word not moved on drain");

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_take)
        else $error("word taken while skid stage is full");

endmodule

// ===== rtl/command_frame_slew_limiter.sv =====
// Command frame slew limiter.
// Slave stream takes one remote-control frame per word: four channel bytes,
// a command byte and an end marker. Frames whose marker is not 0x59 change
// nothing. Accepted frames move each channel toward its request by at most
// that channel's step limit and update the sticky light, run and depth-hold
// flags plus the turn and servo codes.
// Master stream returns exactly one result word per frame: the held channel
// values and flags after the frame, with frame_ok on tuser.
// Configuration channel writes the four step limits (index 0 angle, 1 depth,
// 2 side, 3 forward); it is always ready. The user must use it only
// while the block idles; the block does not enforce this. Throughput: one
// frame per cycle while the skid register is empty; four slew lanes and
// the command decoder each update their held register in the accepting cycle.
// Reset (synchronous, active low) clears held channels, flags and codes,
// empties the output stage and restores step limits to 12, 4, 2, 2.
// When the receiver stalls, a two-word output stage (register plus skid)
// holds results; s_axis_tready drops only once both are full.
module command_frame_slew_limiter
    import cfsl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CH_W-1:0]      i_cfg_data,
    // frame in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // angle_byte, depth_byte, side_byte, forward_byte, command_byte, end_marker
    input  logic [IN_W-1:0]      s_axis_tdata,
    // result out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // angle_cmd, depth_cmd, side_cmd, forward_cmd, light_on, run_enable,
    // thrust_turn, servo_move, depth_hold
    output logic [OUT_W-1:0]     m_axis_tdata,
    // frame_ok
    output logic                 m_axis_tuser
);

    t_lane_bytes     r_limit;
    t_lane_bytes     want;
    t_lane_bytes     lane_next;
    t_cmd_state      cmd_next;
    t_result         result;
    logic [CH_W-1:0] cmd_byte;
    logic [CH_W-1:0] mark_byte;
    logic            take;
    logic            frame_ok;
    logic            apply;

    assign o_cfg_ready = 1'b1;

    // step limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit[i_cfg_index] <= i_cfg_data;
        end
    end

    // unpack the frame
    assign want      = s_axis_tdata[NUM_LANES*CH_W-1:0];
    assign cmd_byte  = s_axis_tdata[NUM_LANES*CH_W +: CH_W];
    assign mark_byte = s_axis_tdata[(NUM_LANES+1)*CH_W +: CH_W];
    assign take      = s_axis_tvalid && s_axis_tready;
    assign frame_ok  = (mark_byte == FRAME_MARK);
    assign apply     = take && frame_ok;

    // one slew lane per channel
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        cfsl_slew_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_apply (apply),
            .i_want  (want[g]),
            .i_limit (r_limit[g]),
            .o_next  (lane_next[g])
        );
    end

    // command byte decoder
    cfsl_cmd_decode u_cmd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_apply (apply),
        .i_cmd   (cmd_byte),
        .o_next  (cmd_next)
    );

    assign result.chan     = lane_next;
    assign result.cmd      = cmd_next;
    assign result.frame_ok = frame_ok;

    // merge and output buffering
    cfsl_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_result (result),
        .o_ready  (s_axis_tready),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_user   (m_axis_tuser)
    );

endmodule

// ===== dv/frame_checker.sv =====
module frame_checker
    import cfsl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write channel
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CH_W-1:0]      i_cfg_data,
    // frame stream
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [IN_W-1:0]      i_in_data,
    // result stream
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [OUT_W-1:0]     i_out_data,
    input  logic                 i_out_ok,
    output int                   o_fail_count,
    output int                   o_pending
);

    // result word with tuser on top, fields from the highest bit down
    typedef struct packed {
        logic                           frame_ok;
        logic                           hold;
        t_servo                         servo;
        t_turn                          turn;
        logic                           run;
        logic                           light;
        logic [NUM_LANES-1:0][CH_W-1:0] chan;
    } t_frame_report;

    localparam string LANE_NAME [NUM_LANES] =
        '{"angle_cmd", "depth_cmd", "side_cmd", "forward_cmd"};

    // shadow copy of the block state
    logic [CH_W-1:0] step_limit [NUM_LANES];
    logic [CH_W-1:0] held_chan  [NUM_LANES];
    logic            lamp_on;
    logic            run_on;
    logic            depth_hold_on;
    t_turn           turn_now;
    t_servo          servo_now;

    t_frame_report   pending_reports [$];
    int              fail_cnt;

    assign o_fail_count = fail_cnt;

    // move toward the request by at most lim, signed compare
    function automatic logic [CH_W-1:0] slew_toward(input logic [CH_W-1:0] held,
                                                    input logic [CH_W-1:0] want,
                                                    input logic [CH_W-1:0] lim);
        int diff;
        diff = int'(want) - int'(held);
        if (diff > int'(lim))
            return held + lim;
        if (diff < -int'(lim))
            return held - lim;
        return want;
    endfunction

    // apply one frame to the shadow state and report what the block shows after it
    function automatic t_frame_report apply_frame(input logic [IN_W-1:0] word);
        t_frame_report   rep;
        logic [CH_W-1:0] cmd;
        logic            ok;
        cmd = word[4*CH_W +: CH_W];
        ok  = (word[5*CH_W +: CH_W] == FRAME_MARK);
        if (ok) begin
            for (int lane = 0; lane < NUM_LANES; lane++)
                held_chan[lane] = slew_toward(held_chan[lane], word[lane*CH_W +: CH_W],
                                              step_limit[lane]);
            // sticky flags only move on their own codes
            if (cmd == CMD_LIGHT_ON)  lamp_on = 1'b1;
            if (cmd == CMD_LIGHT_OFF) lamp_on = 1'b0;
            if (cmd == CMD_RUN_ON)    run_on = 1'b1;
            if (cmd == CMD_RUN_OFF)   run_on = 1'b0;
            if (cmd == CMD_HOLD_ON)   depth_hold_on = 1'b1;
            if (cmd == CMD_HOLD_OFF)  depth_hold_on = 1'b0;
            // turn and servo fall back to none on any other code
            case (cmd)
                CMD_FULL_L: turn_now = TURN_FULL_L;
                CMD_FULL_R: turn_now = TURN_FULL_R;
                CMD_HALF_L: turn_now = TURN_HALF_L;
                CMD_HALF_R: turn_now = TURN_HALF_R;
                default:    turn_now = TURN_NONE;
            endcase
            case (cmd)
                CMD_SERVO_UP: servo_now = SERVO_UP;
                CMD_SERVO_DN: servo_now = SERVO_DOWN;
                default:      servo_now = SERVO_HOLD;
            endcase
        end
        for (int lane = 0; lane < NUM_LANES; lane++)
            rep.chan[lane] = held_chan[lane];
        rep.light    = lamp_on;
        rep.run      = run_on;
        rep.turn     = turn_now;
        rep.servo    = servo_now;
        rep.hold     = depth_hold_on;
        rep.frame_ok = ok;
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [CH_W-1:0] want,
                               input logic [CH_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // watch all three channels on the rising edge
    always @(posedge i_clk) begin : watch
        t_frame_report got;
        t_frame_report want;
        if (!i_rst_n) begin
            step_limit    = '{8'd12, 8'd4, 8'd2, 8'd2};
            held_chan     = '{default: '0};
            lamp_on       = 1'b0;
            run_on        = 1'b0;
            depth_hold_on = 1'b0;
            turn_now      = TURN_NONE;
            servo_now     = SERVO_HOLD;
            pending_reports.delete();
        end else begin
            // result word against the oldest outstanding report
            if (i_out_valid && i_out_ready) begin
                got = t_frame_report'({i_out_ok, i_out_data});
                if (pending_reports.size() == 0) begin
                    $error("result word with no frame outstanding: %h", {i_out_ok, i_out_data});
                    fail_cnt++;
                end else begin
                    want = pending_reports.pop_front();
                    for (int lane = 0; lane < NUM_LANES; lane++)
                        check_field(LANE_NAME[lane], want.chan[lane], got.chan[lane]);
                    check_field("light_on", CH_W'(want.light), CH_W'(got.light));
                    check_field("run_enable", CH_W'(want.run), CH_W'(got.run));
                    check_field("thrust_turn", CH_W'(want.turn), CH_W'(got.turn));
                    check_field("servo_move", CH_W'(want.servo), CH_W'(got.servo));
                    check_field("depth_hold", CH_W'(want.hold), CH_W'(got.hold));
                    check_field("frame_ok", CH_W'(want.frame_ok), CH_W'(got.frame_ok));
                end
            end
            // a frame taken in the same cycle still sees the old limit
            if (i_in_valid && i_in_ready)
                pending_reports.push_back(apply_frame(i_in_data));
            if (i_cfg_valid && i_cfg_ready)
                step_limit[i_cfg_index] = i_cfg_data;
        end
        o_pending = pending_reports.size();
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import cfsl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 80;
    localparam int NUM_CODES   = 12;

    typedef enum {SINK_OPEN, SINK_LIGHT, SINK_HEAVY} t_sink_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CH_W-1:0]      i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tuser;

    int                   fail_count;
    int                   pending;
    logic                 rx_long_hold;
    logic [CH_W-1:0]      last_req [NUM_LANES];

    logic [CH_W-1:0] cmd_codes [NUM_CODES] = '{
        CMD_LIGHT_ON, CMD_LIGHT_OFF, CMD_RUN_ON, CMD_RUN_OFF, CMD_HOLD_ON, CMD_HOLD_OFF,
        CMD_FULL_L, CMD_FULL_R, CMD_HALF_L, CMD_HALF_R, CMD_SERVO_UP, CMD_SERVO_DN
    };

    always #5 i_clk = ~i_clk;

    command_frame_slew_limiter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    frame_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_ok     (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // offer one frame word and hold it until taken, returns on a falling edge
    task automatic offer_frame(input logic [CH_W-1:0] angle, input logic [CH_W-1:0] depth,
                               input logic [CH_W-1:0] side, input logic [CH_W-1:0] fwd,
                               input logic [CH_W-1:0] cmd, input logic [CH_W-1:0] mark);
        s_axis_tdata  = {mark, cmd, fwd, side, depth, angle};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // stop sending until every result word is back
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic program_limits(input logic [CH_W-1:0] angle, input logic [CH_W-1:0] depth,
                                  input logic [CH_W-1:0] side, input logic [CH_W-1:0] fwd);
        logic [CH_W-1:0] lim [NUM_LANES];
        lim = '{angle, depth, side, fwd};
        for (int lane = 0; lane < NUM_LANES; lane++) begin
            i_cfg_index = CFG_IDX_W'(lane);
            i_cfg_data  = lim[lane];
            i_cfg_valid = 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b0;
    endtask

    // random byte, full-scale end, or a small hop from the last request
    function automatic logic [CH_W-1:0] pick_channel(input int lane);
        case ($urandom_range(0, 3))
            0:       last_req[lane] = CH_W'($urandom);
            1:       last_req[lane] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: last_req[lane] = last_req[lane] + CH_W'($urandom_range(0, 6)) - 8'd3;
        endcase
        return last_req[lane];
    endfunction

    // random frames in bursts, mostly well formed, with a drain half way
    task automatic run_phase(input int count, input bit long_hold);
        int              burst;
        logic [CH_W-1:0] cmd;
        logic [CH_W-1:0] mark;
        logic [CH_W-1:0] chan [NUM_LANES];
        burst = 0;
        if (long_hold)
            rx_long_hold = 1'b1;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2)
                drain();
            if (burst == 0) begin
                burst = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
                pause_sender($urandom_range(0, 6));
            end
            burst--;
            mark = ($urandom_range(0, 6) == 0) ? CH_W'($urandom) : FRAME_MARK;
            cmd  = ($urandom_range(0, 9) < 6) ? cmd_codes[$urandom_range(0, NUM_CODES - 1)]
                                              : CH_W'($urandom);
            for (int lane = 0; lane < NUM_LANES; lane++)
                chan[lane] = pick_channel(lane);
            offer_frame(chan[0], chan[1], chan[2], chan[3], cmd, mark);
        end
        drain();
    endtask

    // result sink: random stretches of open, light and heavy stalling, one long hold
    initial begin : result_sink
        int         stretch;
        int         hold_left;
        bit         long_done;
        t_sink_mode mode;
        stretch       = 0;
        hold_left     = 0;
        long_done     = 1'b0;
        mode          = SINK_OPEN;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_long_hold && !long_done) begin
                long_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                if (stretch == 0) begin
                    stretch = $urandom_range(1, 40);
                    mode    = t_sink_mode'($urandom_range(0, 2));
                end
                stretch--;
                case (mode)
                    SINK_OPEN:  m_axis_tready = 1'b1;
                    SINK_LIGHT: m_axis_tready = ($urandom_range(0, 3) != 0);
                    default:    m_axis_tready = ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [CH_W-1:0] ext;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rx_long_hold  = 1'b0;
        last_req      = '{default: '0};
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        // bad markers around the good one: nothing may move
        offer_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, CMD_LIGHT_ON, 8'h00);
        offer_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, CMD_RUN_ON, 8'hFF);
        offer_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, CMD_HOLD_ON, 8'h58);
        offer_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, CMD_FULL_L, 8'h5A);
        // every command code at reset limits, channels driven up then down
        foreach (cmd_codes[k]) begin
            ext = (k < NUM_CODES / 2) ? 8'hFF : 8'h00;
            offer_frame(ext, ext, ext, ext, cmd_codes[k], FRAME_MARK);
        end
        // unknown codes clear turn and servo but keep the sticky flags
        offer_frame(8'h80, 8'h80, 8'h80, 8'h80, 8'h00, FRAME_MARK);
        offer_frame(8'h80, 8'h7F, 8'h01, 8'hFE, 8'hFF, FRAME_MARK);
        // rejected frame must hold turn code and channels
        offer_frame(8'h40, 8'hC0, 8'h10, 8'hF0, CMD_FULL_L, FRAME_MARK);
        offer_frame(8'h00, 8'hFF, 8'h00, 8'hFF, CMD_SERVO_UP, 8'hA6);
        drain();

        // zero step, full step, mixed ends, then random settings
        program_limits(8'd0, 8'd0, 8'd0, 8'd0);
        run_phase(60, 1'b0);
        program_limits(8'd255, 8'd255, 8'd255, 8'd255);
        run_phase(110, 1'b0);
        program_limits(8'd1, 8'd128, 8'd255, 8'd0);
        run_phase(120, 1'b1);
        program_limits(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
        run_phase(120, 1'b0);
        program_limits(CH_W'($urandom_range(0, 8)), CH_W'($urandom_range(0, 8)),
                       CH_W'($urandom_range(0, 8)), CH_W'($urandom_range(0, 8)));
        run_phase(120, 1'b0);
        program_limits(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
        run_phase(120, 1'b0);

        repeat (5) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
